@@ hdl/pffr_pkg.sv @@
// package for the page fault frame replacer
// types, constants and register indexes shared by all modules; no dependencies
`default_nettype none
package pffr_pkg;
  localparam int FRAMES_DEF  = 64;
  localparam int PAGES_DEF   = 1024;
  localparam int REDRAWS_DEF = 100;
  localparam int SKIPS_DEF   = 2;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
  localparam logic [1:0] REG_SEED   = 2'd2;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_SECOND = 2'd2;
  localparam logic [1:0] POL_REDRAW = 2'd3;

  localparam logic [1:0] ST_ABSENT   = 2'd0;
  localparam logic [1:0] ST_READONLY = 2'd1;

  typedef struct packed {
    logic [9:0] fault_page;
    logic [5:0] entry_frame;
    logic [1:0] entry_state;
  } fault_in_t;

  typedef struct packed {
    logic [5:0] granted_frame;
    logic       grant_write;
    logic       fill_from_disk;
    logic       evicted;
    logic [9:0] evicted_page;
    logic       write_back;
    logic       fault_error;
  } fault_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan;       // test marks at scan index, step index
    logic draw;       // step lfsr, start reducing the new word
    logic fold;       // reduce eight more bits of the drawn word
    logic ring_rd;    // read ring at head
    logic skip;       // advance head and tail, read ring
    logic commit;     // update state, make result
    logic promote;    // read-only page made writable
    logic reject;     // error result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_req;     // illegal state, page or frame
    logic resident;    // read-only resident
    logic free_hit;    // scanned frame free
    logic scan_last;   // scan index is last frame
    logic fifo_mode;
    logic second_mode;
    logic redraw_mode;
    logic ptr_mismatch;
    logic cand_dirty;  // candidate frame dirty (valid the cycle after cand loads)
    logic fold_last;   // last fold of the drawn word
  } ctl_sts_t;
endpackage
`default_nettype wire

@@ hdl/pffr_ctrl.sv @@
// controller state machine of the page fault frame replacer
// sequences scan, victim choice and commit; uses pffr_pkg
`default_nettype none
module pffr_ctrl #(
  parameter int REDRAWS = pffr_pkg::REDRAWS_DEF,
  parameter int SKIPS   = pffr_pkg::SKIPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  pffr_pkg::ctl_sts_t  sts,
  output pffr_pkg::ctl_cmd_t  cmd
);
  import pffr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_RING  = 4'd3;
  localparam logic [3:0] S_RCHK  = 4'd4;
  localparam logic [3:0] S_DRAW  = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_FOLD  = 4'd9;

  localparam int CW = $clog2(REDRAWS + SKIPS + 1);

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.bad_req) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end else if (sts.resident) begin
          cmd.promote = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.free_hit) begin
          state_next = S_FCHK;
        end else if (sts.scan_last) begin
          count_next = '0;
          if (sts.fifo_mode) begin
            if (sts.ptr_mismatch) begin
              state_next = S_DONE;
            end else begin
              state_next = S_RING;
            end
          end else begin
            state_next = S_DRAW;
          end
        end
      end
      S_DONE: begin
        cmd.reject = 1'b1;
        state_next = S_IDLE;
      end
      S_RING: begin
        cmd.ring_rd = 1'b1;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        // candidate marks valid here
        if (sts.second_mode && sts.cand_dirty && (count < CW'(SKIPS))) begin
          cmd.skip = 1'b1;
          count_next = count + 1'b1;
          state_next = S_RCHK;
        end else if (sts.second_mode && (count < CW'(SKIPS))) begin
          count_next = count + 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DRAW: begin
        cmd.draw = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (sts.fold_last) begin
          state_next = S_DCHK;
        end
      end
      S_DCHK: begin
        if (sts.redraw_mode && (count < CW'(REDRAWS))) begin
          count_next = count + 1'b1;
          if (sts.cand_dirty) begin
            cmd.draw = 1'b1;
            state_next = S_FOLD;
          end
        end else begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FCHK: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/pffr_datapath.sv @@
// datapath of the page fault frame replacer: frame tables, ring, lfsr, result
// driven by pffr_ctrl commands; uses pffr_pkg
`default_nettype none
module pffr_datapath #(
  parameter int FRAMES = pffr_pkg::FRAMES_DEF,
  parameter int PAGES  = pffr_pkg::PAGES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [31:0]           cfg_data,
  input  pffr_pkg::fault_in_t  req,
  input  pffr_pkg::ctl_cmd_t   cmd,
  output pffr_pkg::ctl_sts_t   sts,
  output pffr_pkg::fault_out_t result,
  output logic                 result_valid
);
  import pffr_pkg::*;

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);

  logic [1:0]  policy;
  logic [6:0]  frames_in_use;
  logic [31:0] lfsr;
  fault_in_t   rq;

  logic [9:0]    owner_mem [FRAMES];
  logic [FW-1:0] ring_mem  [FRAMES];
  logic [FRAMES-1:0] mapped, dirty;
  logic [FW-1:0] head, tail, idx, cand;
  logic          free_path;

  // active frame count, clamped to 1..FRAMES
  logic [NW-1:0] nf;
  always_comb begin
    if (frames_in_use == 7'd0) nf = NW'(1);
    else if (32'(frames_in_use) > 32'(FRAMES)) nf = NW'(FRAMES);
    else nf = NW'(frames_in_use);
  end

  // (v + 1) mod n by restoring reduction; v may lie above n after a frame count change
  function automatic logic [FW-1:0] inc_mod(input logic [FW-1:0] v, input logic [NW-1:0] n);
    logic [NW:0] s;
    logic [NW:0] r;
    s = {1'b0, NW'(v)} + 1'b1;
    r = '0;
    for (int b = NW; b >= 0; b--) begin
      r = {r[NW-1:0], s[b]};
      if (r >= {1'b0, n}) r = r - {1'b0, n};
    end
    return FW'(r);
  endfunction

  // lfsr step; the drawn word is reduced modulo nf eight bits per fold cycle
  logic [31:0] lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);

  logic [31:0]   dword;
  logic [NW-1:0] drem;
  logic [1:0]    dcnt;
  logic [NW-1:0] fold_rem;
  always_comb begin
    logic [NW:0] r;
    r = {1'b0, drem};
    for (int b = 31; b >= 24; b--) begin
      r = {r[NW-1:0], dword[b]};
      if (r >= {1'b0, nf}) r = r - {1'b0, nf};
    end
    fold_rem = NW'(r);
  end

  logic fifo_mode;
  assign fifo_mode = (policy == POL_FIFO) || (policy == POL_SECOND);

  assign sts.bad_req     = (rq.entry_state > ST_READONLY) || (32'(rq.fault_page) >= 32'(PAGES)) ||
                           ((rq.entry_state == ST_READONLY) &&
                            ({1'b0, NW'(rq.entry_frame)} >= {1'b0, nf}));
  assign sts.resident    = (rq.entry_state == ST_READONLY);
  assign sts.free_hit    = !mapped[idx] && !dirty[idx];
  assign sts.scan_last   = ({1'b0, idx} + 1'b1) >= {1'b0, nf};
  assign sts.fifo_mode   = fifo_mode;
  assign sts.second_mode = (policy == POL_SECOND);
  assign sts.redraw_mode = (policy == POL_REDRAW);
  assign sts.ptr_mismatch = (head != tail);
  assign sts.cand_dirty  = dirty[cand];
  assign sts.fold_last   = (dcnt == 2'd3);

  logic [FW-1:0] head_inc, tail_inc;
  assign head_inc = inc_mod(head, nf);
  assign tail_inc = inc_mod(tail, nf);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIFO;
      frames_in_use <= 7'd64;
      lfsr <= 32'd1;
      mapped <= '0;
      dirty <= '0;
      head <= '0;
      tail <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.reject | cmd.promote | cmd.commit;
      if (cmd.draw) begin
        lfsr <= lfsr_step;
      end else if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY: policy <= cfg_data[1:0];
          REG_FRAMES: frames_in_use <= cfg_data[6:0];
          REG_SEED:   lfsr <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (cmd.skip) begin
        head <= head_inc;
        tail <= tail_inc;
      end
      if (cmd.promote) begin
        mapped[rq.entry_frame[FW-1:0]] <= 1'b1;
        dirty[rq.entry_frame[FW-1:0]] <= 1'b1;
      end
      if (cmd.commit) begin
        mapped[cand] <= 1'b1;
        dirty[cand] <= 1'b0;
        if (fifo_mode) tail <= tail_inc;
        if (!free_path) head <= head_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    fault_out_t res;
    res = '0;
    if (cmd.reject) begin
      res.fault_error = 1'b1;
    end
    if (cmd.promote) begin
      res.granted_frame = 6'(rq.entry_frame);
      res.grant_write = 1'b1;
    end
    if (cmd.commit) begin
      res.granted_frame = 6'(cand);
      res.fill_from_disk = 1'b1;
      if (mapped[cand] || dirty[cand]) begin
        res.evicted = 1'b1;
        res.evicted_page = owner_mem[cand];
        res.write_back = dirty[cand];
      end
    end
    if (cmd.reject || cmd.promote || cmd.commit) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq <= req;
      idx <= '0;
      free_path <= 1'b0;
    end
    if (cmd.scan) begin
      if (!mapped[idx] && !dirty[idx]) begin
        cand <= idx;
        free_path <= 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end
    if (cmd.draw) begin
      dword <= lfsr_step;
      drem <= '0;
      dcnt <= '0;
    end
    if (cmd.fold) begin
      dword <= dword << 8;
      drem <= fold_rem;
      dcnt <= dcnt + 1'b1;
      if (dcnt == 2'd3) cand <= FW'(fold_rem);
    end
    if (cmd.ring_rd) begin
      cand <= ring_mem[head];
    end
    if (cmd.skip) begin
      cand <= ring_mem[head_inc];
    end
    if (cmd.promote) begin
      owner_mem[rq.entry_frame[FW-1:0]] <= rq.fault_page;
    end
    if (cmd.commit) begin
      owner_mem[cand] <= rq.fault_page;
      if (fifo_mode) ring_mem[tail] <= cand;
    end
  end
endmodule
`default_nettype wire

@@ hdl/page_fault_frame_replacer.sv @@
// page fault frame replacer: one result per fault; errors and read-only upgrades
// are answered from the decode state, a free frame found by the scan is granted, the
// scan covers one frame per cycle, else the victim comes from the ring, with skips
// of dirty frames, or from lfsr draws; busy until done, the next start is taken at
// the edge that ends the done cycle; the receiver cannot stall
// synchronous reset: frames free, ring pointers zero, lfsr 1, policy fifo, 64 frames
`default_nettype none
module page_fault_frame_replacer #(
  parameter int FRAMES  = pffr_pkg::FRAMES_DEF,
  parameter int PAGES   = pffr_pkg::PAGES_DEF,
  parameter int REDRAWS = pffr_pkg::REDRAWS_DEF,
  parameter int SKIPS   = pffr_pkg::SKIPS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  pffr_pkg::fault_in_t  fault,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [31:0]           cfg_data,
  output logic                 done,
  output pffr_pkg::fault_out_t result
);
  import pffr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  pffr_ctrl #(.REDRAWS(REDRAWS), .SKIPS(SKIPS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  pffr_datapath #(.FRAMES(FRAMES), .PAGES(PAGES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(fault), .cmd(cmd), .sts(sts), .result(result), .result_valid(done)
  );
endmodule
`default_nettype wire
